// ===== hw/rtl/bfdh_pkg.sv =====
// Shared types for the bloom filter block: controller states and control/status bundles.
package bfdh_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FOLD0,
		ST_PSTART,
		ST_DSTART,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic fold_in;
		logic fold_zero;
		logic hash_reset;
		logic probe_init;
		logic probe_next;
		logic div_load;
		logic div_step;
		logic mem_rd;
		logic mem_upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic probes_zero;
		logic div_last;
		logic probe_last;
	} sts_t;

endpackage

// ===== hw/rtl/bfdh_if.sv =====
// Request and result channel interfaces of the bloom filter block.
interface bfdh_req_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic signed [7:0] key_char;
	logic              last_char;

	modport source (output valid, output kind, output key_char, output last_char,
		input ready);
	modport sink (input valid, input kind, input key_char, input last_char,
		output ready);
endinterface

interface bfdh_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic was_query;

	modport source (output valid, output hit, output was_query, input ready);
	modport sink (input valid, input hit, input was_query, output ready);
endinterface

// ===== hw/rtl/bfdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bfdh_ctrl.sv =====
// Controller state machine: clearing pass, key folding, probe sequencing, result hand-off.
module bfdh_ctrl import bfdh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.fold_in = 1'b1;
					if (in_last) begin
						state_d = ST_FOLD0;
					end
				end
			end
			ST_FOLD0: begin
				// terminating zero character
				cmd.fold_zero = 1'b1;
				state_d       = ST_PSTART;
			end
			ST_PSTART: begin
				cmd.probe_init = 1'b1;
				state_d        = sts.probes_zero ? ST_DONE : ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.mem_upd    = 1'b1;
				cmd.probe_next = 1'b1;
				state_d        = sts.probe_last ? ST_DONE : ST_DSTART;
			end
			ST_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load   = 1'b1;
					cmd.hash_reset = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bfdh_dp.sv =====
// Datapath: running hashes, probe index generator, iterative modulo unit and filter bit store.
module bfdh_dp import bfdh_pkg::*; #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_HASHES      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              kind,
	input  logic signed [7:0] key_char,
	input  logic [4:0]        num_hashes,
	input  logic [16:0]       filter_bits,
	output logic              hit,
	output logic              was_query
);

	localparam logic [63:0] DJB_SEED = 64'd5381;
	localparam int DIV_BITS = 4;
	localparam int DIV_CYC  = 64 / DIV_BITS;
	localparam int CNT_W    = $clog2(DIV_CYC);
	localparam int MOD_W    = $clog2(MAX_FILTER_BITS + 1);
	localparam int ROW_W    = (MAX_FILTER_BITS >= 32) ? 32 : 8;
	localparam int ROW_LOG  = $clog2(ROW_W);
	localparam int ROWS     = (MAX_FILTER_BITS + ROW_W - 1) / ROW_W;
	localparam int RAW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W    = ROW_LOG + RAW_W;

	logic [63:0]      djb_q, sdbm_q, c64, djb_nx, sdbm_nx;
	logic [63:0]      acc_q, sh_q;
	logic [4:0]       idx_q, probes;
	logic             kind_q, hit_q;
	logic [MOD_W-1:0] mod_eff, rem_q, rem_nx;
	logic [MOD_W:0]   trial;
	logic [CNT_W-1:0] cnt_q;
	logic [RAW_W-1:0] clr_cnt_q, row;
	logic [IDX_W-1:0] kx;
	logic [ROW_W-1:0] rdata, mask, wdata;
	logic             we;
	logic [RAW_W-1:0] waddr;

	// effective register values
	always_comb begin
		probes = (32'(num_hashes) > MAX_HASHES) ? 5'(MAX_HASHES) : num_hashes;
		if (filter_bits == 17'd0) begin
			mod_eff = MOD_W'(1);
		end else if (32'(filter_bits) > MAX_FILTER_BITS) begin
			mod_eff = MOD_W'(MAX_FILTER_BITS);
		end else begin
			mod_eff = MOD_W'(filter_bits);
		end
	end

	assign c64     = cmd.fold_zero ? 64'd0 : {{56{key_char[7]}}, key_char};
	assign djb_nx  = (djb_q << 5) + djb_q + c64;
	assign sdbm_nx = c64 + (sdbm_q << 6) + (sdbm_q << 16) - sdbm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			djb_q     <= DJB_SEED;
			sdbm_q    <= 64'd0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.hash_reset) begin
				djb_q  <= DJB_SEED;
				sdbm_q <= 64'd0;
			end else if (cmd.fold_in || cmd.fold_zero) begin
				djb_q  <= djb_nx;
				sdbm_q <= sdbm_nx;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + RAW_W'(1);
			end
		end
	end

	// restoring remainder, DIV_BITS dividend bits per cycle
	always_comb begin
		rem_nx = rem_q;
		trial  = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			trial = {rem_nx, sh_q[63-j]};
			if (trial >= {1'b0, mod_eff}) begin
				trial = trial - {1'b0, mod_eff};
			end
			rem_nx = trial[MOD_W-1:0];
		end
	end

	assign kx   = IDX_W'(rem_q);
	assign row  = kx[IDX_W-1:ROW_LOG];
	assign mask = ROW_W'(1) << kx[ROW_LOG-1:0];

	always_ff @(posedge clk) begin
		if (cmd.fold_in) begin
			kind_q <= kind;
		end
		if (cmd.probe_init) begin
			// probe i accumulates djb + i*sdbm + i*i incrementally
			acc_q <= djb_q;
			idx_q <= 5'd0;
			hit_q <= 1'b1;
		end
		if (cmd.probe_next) begin
			acc_q <= acc_q + sdbm_q + 64'({idx_q, 1'b1});
			idx_q <= idx_q + 5'd1;
		end
		if (cmd.div_load) begin
			sh_q  <= acc_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			sh_q  <= sh_q << DIV_BITS;
			rem_q <= rem_nx;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.mem_upd && kind_q && !rdata[kx[ROW_LOG-1:0]]) begin
			hit_q <= 1'b0;
		end
		if (cmd.out_load) begin
			hit       <= kind_q & hit_q;
			was_query <= kind_q;
		end
	end

	assign we    = cmd.clr_wr || (cmd.mem_upd && !kind_q);
	assign waddr = cmd.clr_wr ? clr_cnt_q : row;
	assign wdata = cmd.clr_wr ? '0 : (rdata | mask);

	bfdh_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.mem_rd),
		.raddr (row),
		.rdata (rdata)
	);

	always_comb begin
		sts.clr_last    = (clr_cnt_q == RAW_W'(ROWS - 1));
		sts.probes_zero = (probes == 5'd0);
		sts.div_last    = (cnt_q == CNT_W'(DIV_CYC - 1));
		sts.probe_last  = (idx_q == probes - 5'd1);
	end

endmodule

// ===== hw/rtl/bloom_filter_double_hash_top.sv =====
// Bloom filter with djb2/sdbm double hashing over keys streamed one character per request.
// Non-final characters are folded into both hashes as they are accepted. After the final
// character is folded, the terminating zero is folded in and probing is set up; each of the
// num_hashes probes loads the iterative modulo unit, runs the 64-bit modulo (4 dividend bits
// a cycle), reads the filter RAM row and then updates it: a read-modify-write for an insert,
// a bit check for a query. The result is loaded once the output register is free.
// After reset the filter RAM is swept clear one 32-bit row per cycle,
// ceil(MAX_FILTER_BITS/32) rows (2048 by default), during which no request is taken;
// configuration writes are taken at any time. A finished result waits in an output
// register while characters of the next key are accepted.
module bloom_filter_double_hash_top import bfdh_pkg::*; #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_HASHES      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bfdh_req_if.sink    req,
	bfdh_rsp_if.source  rsp
);

	localparam logic REG_NUM_HASHES  = 1'b0;
	localparam logic REG_FILTER_BITS = 1'b1;

	logic [4:0]  num_hashes_q;
	logic [16:0] filter_bits_q;
	logic        cfg_wr;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q  <= 5'd3;
			filter_bits_q <= 17'h10000;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NUM_HASHES:  num_hashes_q  <= pwdata[4:0];
				REG_FILTER_BITS: filter_bits_q <= pwdata[16:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUM_HASHES:  prdata = {27'd0, num_hashes_q};
			REG_FILTER_BITS: prdata = {15'd0, filter_bits_q};
		endcase
	end

	bfdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_last   (req.last_char),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bfdh_dp #(
		.MAX_FILTER_BITS (MAX_FILTER_BITS),
		.MAX_HASHES      (MAX_HASHES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (req.kind),
		.key_char    (req.key_char),
		.num_hashes  (num_hashes_q),
		.filter_bits (filter_bits_q),
		.hit         (rsp.hit),
		.was_query   (rsp.was_query)
	);

endmodule

// ===== dv/bfdh_tb_pkg.sv =====
// Register addresses and request kinds shared by the bloom filter testbench modules.
package bfdh_tb_pkg;

	localparam logic [2:0] ADDR_NUM_HASHES  = 3'd0;
	localparam logic [2:0] ADDR_FILTER_BITS = 3'd4;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

endpackage

// ===== dv/bloom_filter_double_hash_checker.sv =====
// Monitor and scoreboard: tracks register writes, predicts each key's answer, checks results.
module bloom_filter_double_hash_checker import bfdh_tb_pkg::*; #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_HASHES      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	bfdh_req_if         req,
	bfdh_rsp_if         rsp,
	output int          fail_count,
	output int          waiting_count,
	output int          answer_count,
	output int          hit_count
);

	typedef struct packed {
		logic hit;
		logic was_query;
	} key_answer_t;

	localparam logic [63:0] DJB_SEED = 64'd5381;

	logic [63:0]              djb_sum;
	logic [63:0]              sdbm_sum;
	logic [4:0]               probes_cfg;
	logic [16:0]              fbits_cfg;
	bit [MAX_FILTER_BITS-1:0] bloom_bits;
	key_answer_t              answer_q[$];
	int                       fails;
	int                       answers;
	int                       hits;

	function automatic void fold_char(input logic [63:0] c);
		djb_sum  = (djb_sum << 5) + djb_sum + c;
		sdbm_sum = c + (sdbm_sum << 6) + (sdbm_sum << 16) - sdbm_sum;
	endfunction

	// Folds the terminating zero, runs the probes against the bit store, reseeds the hashes.
	function automatic key_answer_t finish_key(input logic kind);
		key_answer_t ans;
		logic [63:0] probes;
		logic [63:0] modulus;
		logic [63:0] idx;
		logic [63:0] i;
		ans.hit = 1'b1;
		ans.was_query = kind;
		fold_char(64'd0);
		probes = (probes_cfg > MAX_HASHES) ? 64'(MAX_HASHES) : 64'(probes_cfg);
		modulus = (fbits_cfg == 0) ? 64'd1 : 64'(fbits_cfg);
		if (modulus > 64'(MAX_FILTER_BITS))
			modulus = 64'(MAX_FILTER_BITS);
		for (i = 0; i < probes; i++) begin
			idx = (djb_sum + i * sdbm_sum + i * i) % modulus;
			if (kind == KIND_QUERY) begin
				if (!bloom_bits[idx])
					ans.hit = 1'b0;
			end else begin
				bloom_bits[idx] = 1'b1;
			end
		end
		if (kind != KIND_QUERY)
			ans.hit = 1'b0;
		djb_sum = DJB_SEED;
		sdbm_sum = 64'd0;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_answer_t want;
		if (!arst_n) begin
			djb_sum = DJB_SEED;
			sdbm_sum = 64'd0;
			probes_cfg = 5'd3;
			fbits_cfg = 17'd65536;
			bloom_bits = '0;
			answer_q.delete();
			fails = 0;
			answers = 0;
			hits = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_NUM_HASHES: probes_cfg = pwdata[4:0];
					ADDR_FILTER_BITS: fbits_cfg = pwdata[16:0];
					default: ;
				endcase
			end
			// result side first: a result never belongs to a key ending at the same edge
			if (rsp.valid && rsp.ready) begin
				answers++;
				if (rsp.was_query && rsp.hit)
					hits++;
				if (answer_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with nothing pending: hit=%b was_query=%b",
							$time, rsp.hit, rsp.was_query);
				end else begin
					want = answer_q.pop_front();
					if (rsp.hit !== want.hit || rsp.was_query !== want.was_query) begin
						fails++;
						if (fails <= 10)
							$display("%0t: result %0d: hit exp %b got %b, was_query exp %b got %b",
								$time, answers, want.hit, rsp.hit, want.was_query,
								rsp.was_query);
					end
				end
			end
			if (req.valid && req.ready) begin
				fold_char({{56{req.key_char[7]}}, req.key_char});
				if (req.last_char)
					answer_q.push_back(finish_key(req.kind));
			end
		end
		fail_count <= fails;
		waiting_count <= answer_q.size();
		answer_count <= answers;
		hit_count <= hits;
	end

endmodule

// ===== dv/bloom_filter_double_hash_top_tb.sv =====
// Testbench top: clock, reset, key and register stimulus for the bloom filter, and the verdict.
module bloom_filter_double_hash_top_tb;
	import bfdh_tb_pkg::*;

	localparam int     CLK_HALF    = 6;
	localparam int     KEY_MAX     = 24;
	localparam int     RING        = 64;
	localparam int     N_PHASES    = 8;
	localparam int     PHASE_CHARS = 1550 / N_PHASES;
	localparam int     SETTLE      = 24;
	localparam int     DRAIN_LIMIT = 20000;
	localparam longint RUN_LIMIT   = 64'd48_000_000;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bfdh_req_if req();
	bfdh_rsp_if rsp();

	int         fail_count;
	int         waiting_count;
	int         answer_count;
	int         hit_count;
	idle_mode_t idle_mode;
	int         chars_sent;
	int         settings_used;
	logic [7:0] key_buf [KEY_MAX];
	int         key_len;
	logic [7:0] kept_keys [RING][KEY_MAX];
	int         kept_len [RING];
	int         kept_total;

	bloom_filter_double_hash_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.rsp     (rsp)
	);

	bloom_filter_double_hash_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.req           (req),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.waiting_count (waiting_count),
		.answer_count  (answer_count),
		.hit_count     (hit_count)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic int idle_pct(input idle_mode_t mode, input logic sender);
		case (mode)
			IDLE_SEND: return sender ? 53 : 0;
			IDLE_RECV: return sender ? 0 : 53;
			IDLE_BOTH: return 13;
			default: return 0;
		endcase
	endfunction

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(0, 99) >= idle_pct(idle_mode, 1'b0));
		end
	end

	// valid stays high after acceptance; the next request or the drain decides its level
	task automatic put_char(input logic kind, input logic [7:0] ch, input logic last);
		while ($urandom_range(0, 99) < idle_pct(idle_mode, 1'b1)) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.key_char <= ch;
		req.last_char <= last;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		chars_sent++;
	endtask

	// kind only matters on the last character, so earlier ones carry a random kind
	task automatic send_key(input logic kind);
		int slot;
		for (int j = 0; j < key_len; j++)
			put_char(j == key_len - 1 ? kind : 1'($urandom_range(0, 1)), key_buf[j],
				j == key_len - 1);
		if (kind == KIND_INSERT) begin
			slot = kept_total % RING;
			kept_keys[slot] = key_buf;
			kept_len[slot] = key_len;
			kept_total++;
		end
	endtask

	// chars packed low byte first
	task automatic directed_key(input logic kind, input int len, input logic [31:0] chars);
		key_len = len;
		for (int j = 0; j < len; j++)
			key_buf[j] = chars[8*j +: 8];
		send_key(kind);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		req.valid <= 1'b0;
		@(posedge clk);
		while (waiting_count != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_filter(input logic [31:0] probes, input logic [31:0] fbits);
		for (int r = 0; r < 2; r++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= (r == 0) ? ADDR_NUM_HASHES : ADDR_FILTER_BITS;
			pwdata <= (r == 0) ? probes : fbits;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int          phase_start;
		int          slot;
		int          roll;
		logic        kind;
		logic [31:0] probes;
		logic [31:0] fbits;
		req.valid <= 1'b0;
		req.kind <= 1'b0;
		req.key_char <= 8'd0;
		req.last_char <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'd0;
		arst_n <= 1'b0;
		idle_mode = IDLE_NONE;
		chars_sent = 0;
		kept_total = 0;
		settings_used = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty-filter miss, char extremes, insert then query, order matters
		directed_key(KIND_QUERY, 1, 32'h41);
		directed_key(KIND_INSERT, 2, 32'h7F80);
		directed_key(KIND_QUERY, 2, 32'h7F80);
		directed_key(KIND_QUERY, 2, 32'h807F);
		directed_key(KIND_INSERT, 1, 32'h00);
		directed_key(KIND_QUERY, 1, 32'h00);
		directed_key(KIND_QUERY, 1, 32'hFF);
		directed_key(KIND_INSERT, 3, 32'hFFFFFF);
		directed_key(KIND_QUERY, 3, 32'hFFFFFF);
		directed_key(KIND_INSERT, 4, 32'h64636261);
		directed_key(KIND_QUERY, 4, 32'h64636261);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin probes = 32'd1;  fbits = 32'd1;      end
				1: begin probes = 32'd0;  fbits = 32'd0;      end  // no probes, size 0 -> 1
				2: begin probes = 32'd16; fbits = 32'd65536;  end
				3: begin probes = 32'd31; fbits = 32'd131071; end  // both saturate
				4: begin probes = 32'd4;  fbits = 32'd8;      end
				5: begin probes = 32'd2;  fbits = 32'd65537;  end
				default: begin
					probes = $urandom_range(1, 16);
					fbits = $urandom_range(1, 65536);
				end
			endcase
			// junk above the register width must be dropped
			if (p % 2 == 1) begin
				probes |= $urandom << 5;
				fbits |= $urandom << 17;
			end
			program_filter(probes, fbits);
			idle_mode = idle_mode_t'(p % 4);
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				roll = $urandom_range(0, 99);
				if (roll < 40 && kept_total > 0) begin
					slot = $urandom_range(0, (kept_total < RING ? kept_total : RING) - 1);
					key_buf = kept_keys[slot];
					key_len = kept_len[slot];
					kind = KIND_QUERY;
				end else begin
					roll = $urandom_range(0, 99);
					key_len = roll < 80 ? $urandom_range(1, 6)
						: roll < 95 ? $urandom_range(7, 16) : $urandom_range(17, KEY_MAX);
					for (int j = 0; j < key_len; j++)
						key_buf[j] = 8'($urandom_range(0, 255));
					kind = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_QUERY;
				end
				send_key(kind);
			end
			drain();
		end

		$display("Streamed %0d key characters under %0d filter settings, idle patterns varied.",
			chars_sent, settings_used);
		$display("Checked %0d answers (%0d query hits), %0d still pending.",
			answer_count, hit_count, waiting_count);
		if (fail_count == 0 && waiting_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
